// ===== design/bea3_pkg.sv =====
// ----------------------------------------------------------------------------
// bea3_pkg
// Shared types, constants and the micro-rotation angle table for the
// bearing/elevation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bea3_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned ANGLE_ITER_DEF  = 24;

  // Datapath and angle accumulator widths (angles in 1e-9 degree units).
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned ANG_W      = 40;
  localparam int unsigned NORM_TOP   = 55;
  localparam int unsigned NORM_STEPS = 6;
  localparam int unsigned CONE_STEP  = 3;

  localparam int unsigned AZ_W = 9;
  localparam int unsigned EL_W = 8;

  localparam logic signed [ANG_W-1:0] ANG_90  = 40'sd90000000000;
  localparam logic signed [ANG_W-1:0] ANG_360 = 40'sd360000000000;

  // CORDIC gain fraction, Q30.
  localparam logic signed [30:0] GAIN_FRAC = 31'sd694453539;
  localparam int unsigned GAIN_SHIFT = 30;

  // Degree extraction: floor(a / 1e9) = floor((a >> 9) * RECIP >> 51).
  localparam int unsigned DIV_SHIFT   = 9;
  localparam int unsigned QN_W        = ANG_W - 1 - DIV_SHIFT;
  localparam int unsigned RECIP_W     = 31;
  localparam int unsigned RECIP_SHIFT = 51;
  localparam logic [RECIP_W-1:0] DEG_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd1953125 + 64'd1);
  localparam int unsigned PROD_W = QN_W + RECIP_W;
  localparam int unsigned DEG_W  = PROD_W - RECIP_SHIFT;

  localparam logic signed [63:0] RAD_IN_UNITS = 64'sd57295779513;

  localparam logic signed [63:0] ATAN_SMALL [16] = '{
    64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
    64'sd3576334375,  64'sd1789910608,  64'sd895173710,   64'sd447614171,
    64'sd223810500,   64'sd111905677,   64'sd55952892,    64'sd27976453,
    64'sd13988227,    64'sd6994114,     64'sd3497057,     64'sd1748528
  };

  typedef struct packed {
    logic zxy;
    logic dxz;
    logic dyz;
    logic dxp;
    logic dyp;
    logic diag;
    logic dzz;
    logic dzp;
    logic cone;
  } flags_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
  } vec_t;

  typedef struct packed {
    flags_t                   f;
    logic signed [DATA_W-1:0] dzk;
  } az_aux_t;

  typedef struct packed {
    flags_t                  f;
    logic signed [ANG_W-1:0] za;
  } el_aux_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic [DATA_W-1:0]        m;
    flags_t                   f;
  } norm_t;

  function automatic logic signed [ANG_W-1:0] step_angle(input int unsigned i);
    logic signed [63:0] v;
    if (i < 16) begin
      v = ATAN_SMALL[i[3:0]];
    end else if (i > 62) begin
      v = '0;
    end else begin
      v = (RAD_IN_UNITS + (64'sd1 <<< (i - 1))) >>> i;
    end
    return v[ANG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/bearing_elevation_3d.sv =====
// ----------------------------------------------------------------------------
// bearing_elevation_3d
// Azimuth and elevation in whole degrees from one 3D point to another.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat enters per cycle while the output queue has room
// and one result beat leaves per cycle while out_stall_i is low; most of the
// depth is the two chains of unrolled CORDIC micro-rotation stages (azimuth,
// then elevation on the azimuth magnitude). A two-beat output queue sits after
// the last stage, so the pipeline keeps taking input beats while a finished
// result waits; in_stall_o rises only when that queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bearing_elevation_3d
  import bea3_pkg::*;
#(
  parameter int unsigned COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] from_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] from_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] from_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] to_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] to_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] to_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [AZ_W-1:0]                    azimuth_deg_o,
  output logic signed [EL_W-1:0]             elevation_deg_o
);

  localparam int unsigned DW  = COORD_WIDTH + 1;        // difference width
  localparam int unsigned CW  = COORD_WIDTH;            // magnitude width
  localparam int unsigned LO  = (CW + 1) / 2;           // square split, low part
  localparam int unsigned HI  = CW - LO;
  localparam int unsigned SQW = 2 * CW;
  localparam int unsigned IT  = ANGLE_ITERATIONS;
  localparam int unsigned AZX = $bits(az_aux_t);
  localparam int unsigned ELX = $bits(el_aux_t);

  // Global advance: the whole pipe moves while the output queue has room.
  logic       en;
  logic [1:0] cnt_q;

  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  // --------------------------------------------------------------------------
  // Stage S0: exact coordinate differences.
  // --------------------------------------------------------------------------
  logic                 s0_vld_q;
  logic signed [DW-1:0] s0_dx_q, s0_dy_q, s0_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_dx_q <= DW'(to_x_i) - DW'(from_x_i);
      s0_dy_q <= DW'(to_y_i) - DW'(from_y_i);
      s0_dz_q <= DW'(to_z_i) - DW'(from_z_i);
    end
  end

  // --------------------------------------------------------------------------
  // Stage S1: magnitudes, largest magnitude and special-case flags.
  // --------------------------------------------------------------------------
  logic                 s1_vld_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic [CW-1:0]        s1_ax_q, s1_ay_q, s1_az_q, s1_m_q;
  flags_t               s1_f_q;

  logic [CW-1:0] ax_d, ay_d, az_d, mxy_d;
  flags_t        f_d;

  always_comb begin
    ax_d  = s0_dx_q[DW-1] ? CW'(-s0_dx_q) : CW'(s0_dx_q);
    ay_d  = s0_dy_q[DW-1] ? CW'(-s0_dy_q) : CW'(s0_dy_q);
    az_d  = s0_dz_q[DW-1] ? CW'(-s0_dz_q) : CW'(s0_dz_q);
    mxy_d = (ax_d > ay_d) ? ax_d : ay_d;
    f_d.dxz  = (s0_dx_q == '0);
    f_d.dyz  = (s0_dy_q == '0);
    f_d.dzz  = (s0_dz_q == '0);
    f_d.zxy  = f_d.dxz && f_d.dyz;
    f_d.dxp  = !s0_dx_q[DW-1] && !f_d.dxz;
    f_d.dyp  = !s0_dy_q[DW-1] && !f_d.dyz;
    f_d.dzp  = !s0_dz_q[DW-1] && !f_d.dzz;
    f_d.diag = (ax_d == ay_d);
    f_d.cone = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q <= s0_dx_q;
      s1_dy_q <= s0_dy_q;
      s1_dz_q <= s0_dz_q;
      s1_ax_q <= ax_d;
      s1_ay_q <= ay_d;
      s1_az_q <= az_d;
      s1_m_q  <= (az_d > mxy_d) ? az_d : mxy_d;
      s1_f_q  <= f_d;
    end
  end

  // --------------------------------------------------------------------------
  // Cone test dz^2 == dx^2 + dy^2, exact, in three steps beside the
  // normalizer: split partial products, squares, then sum and compare.
  // --------------------------------------------------------------------------
  logic [2*HI-1:0]    pp_hh_q [3];
  logic [HI+LO-1:0]   pp_hl_q [3];
  logic [2*LO-1:0]    pp_ll_q [3];
  logic [SQW-1:0]     sq_q    [3];
  logic               cone_q;
  logic [CW-1:0]      mag_in  [3];

  assign mag_in[0] = s1_ax_q;
  assign mag_in[1] = s1_ay_q;
  assign mag_in[2] = s1_az_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pp_hh_q[k] <= mag_in[k][CW-1:LO] * mag_in[k][CW-1:LO];
        pp_hl_q[k] <= mag_in[k][CW-1:LO] * mag_in[k][LO-1:0];
        pp_ll_q[k] <= mag_in[k][LO-1:0] * mag_in[k][LO-1:0];
        sq_q[k]    <= (SQW'(pp_hh_q[k]) << (2 * LO)) + (SQW'(pp_hl_q[k]) << (LO + 1))
                      + SQW'(pp_ll_q[k]);
      end
      cone_q <= ((SQW + 1)'(sq_q[0]) + (SQW + 1)'(sq_q[1])) == (SQW + 1)'(sq_q[2]);
    end
  end

  // --------------------------------------------------------------------------
  // Normalizer: shift all three differences left by a common amount so the
  // largest magnitude, if nonzero, lands in [2^55, 2^56). One shift weight per stage.
  // --------------------------------------------------------------------------
  logic  norm_vld [0:NORM_STEPS];
  norm_t norm     [0:NORM_STEPS];

  assign norm_vld[0] = s1_vld_q;
  assign norm[0]     = '{x: DATA_W'(s1_dx_q), y: DATA_W'(s1_dy_q), z: DATA_W'(s1_dz_q),
                         m: DATA_W'(s1_m_q), f: s1_f_q};

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int unsigned K = 32 >> j;
    norm_t nd;

    always_comb begin
      nd = norm[j];
      if (norm[j].m[DATA_W-1:NORM_TOP+1-K] == '0) begin
        nd.x = norm[j].x <<< K;
        nd.y = norm[j].y <<< K;
        nd.z = norm[j].z <<< K;
        nd.m = norm[j].m << K;
      end
      if (j == CONE_STEP) begin
        nd.f.cone = cone_q;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        norm_vld[j+1] <= 1'b0;
      end else if (en) begin
        norm_vld[j+1] <= norm_vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        norm[j+1] <= nd;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage P: quadrant pre-rotation for the azimuth; gain partial products
  // for the elevation input.
  // --------------------------------------------------------------------------
  logic                     p_vld_q;
  vec_t                     p_vec_q;
  logic signed [DATA_W-1:0] p_dz_q;
  logic signed [57:0]       p_hip_q;
  logic [59:0]              p_lop_q;
  flags_t                   p_f_q;
  vec_t                     p_vec_d;
  norm_t                    nl;

  assign nl = norm[NORM_STEPS];

  always_comb begin
    p_vec_d = '{x: nl.x, y: nl.y, z: '0};
    if (nl.x < 0) begin
      if (nl.y >= 0) begin
        p_vec_d = '{x: nl.y, y: -nl.x, z: ANG_90};
      end else begin
        p_vec_d = '{x: -nl.y, y: nl.x, z: -ANG_90};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= norm_vld[NORM_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_vec_q <= p_vec_d;
      p_dz_q  <= nl.z;
      p_hip_q <= $signed(nl.z[NORM_TOP+1:GAIN_SHIFT]) * GAIN_FRAC;
      p_lop_q <= nl.z[GAIN_SHIFT-1:0] * 30'(GAIN_FRAC);
      p_f_q   <= nl.f;
    end
  end

  // --------------------------------------------------------------------------
  // Stage Q: finish the gain-scaled dz.
  // --------------------------------------------------------------------------
  logic    q_vld_q;
  vec_t    q_vec_q;
  az_aux_t q_aux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= 1'b0;
    end else if (en) begin
      q_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_vec_q     <= p_vec_q;
      q_aux_q.f   <= p_f_q;
      q_aux_q.dzk <= p_dz_q + DATA_W'(p_hip_q)
                     + DATA_W'(p_lop_q[59:GAIN_SHIFT]);
    end
  end

  // --------------------------------------------------------------------------
  // Azimuth CORDIC chain.
  // --------------------------------------------------------------------------
  logic           az_vld [0:IT];
  vec_t           az_vec [0:IT];
  logic [AZX-1:0] az_aux [0:IT];

  assign az_vld[0] = q_vld_q;
  assign az_vec[0] = q_vec_q;
  assign az_aux[0] = q_aux_q;

  for (genvar i = 0; i < IT; i++) begin : g_az
    bea3_cordic_stage #(
      .STAGE (i),
      .AUX_W (AZX)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (az_vld[i]),
      .vec_i  (az_vec[i]),
      .aux_i  (az_aux[i]),
      .vld_o  (az_vld[i+1]),
      .vec_o  (az_vec[i+1]),
      .aux_o  (az_aux[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Elevation CORDIC chain on (azimuth magnitude, gain-scaled dz).
  // --------------------------------------------------------------------------
  az_aux_t        az_end;
  el_aux_t        el_start;
  logic           el_vld [0:IT];
  vec_t           el_vec [0:IT];
  logic [ELX-1:0] el_aux [0:IT];

  assign az_end     = az_aux_t'(az_aux[IT]);
  assign el_start   = '{f: az_end.f, za: az_vec[IT].z};
  assign el_vld[0]  = az_vld[IT];
  assign el_vec[0]  = '{x: az_vec[IT].x, y: az_end.dzk, z: '0};
  assign el_aux[0]  = el_start;

  for (genvar i = 0; i < IT; i++) begin : g_el
    bea3_cordic_stage #(
      .STAGE (i),
      .AUX_W (ELX)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (el_vld[i]),
      .vec_i  (el_vec[i]),
      .aux_i  (el_aux[i]),
      .vld_o  (el_vld[i+1]),
      .vec_o  (el_vec[i+1]),
      .aux_o  (el_aux[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage D1: wrap azimuth into [0, 360), take |elevation|, drop 9 low bits.
  // --------------------------------------------------------------------------
  el_aux_t                 el_end;
  logic signed [ANG_W-1:0] za_adj, ze_abs;
  logic                    d1_vld_q;
  logic [QN_W-1:0]         d1_qa_q, d1_qe_q;
  logic                    d1_neg_q;
  flags_t                  d1_f_q;

  assign el_end = el_aux_t'(el_aux[IT]);

  always_comb begin
    za_adj = (el_end.za < 0) ? el_end.za + ANG_360 : el_end.za;
    ze_abs = (el_vec[IT].z < 0) ? -el_vec[IT].z : el_vec[IT].z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= 1'b0;
    end else if (en) begin
      d1_vld_q <= el_vld[IT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_qa_q  <= za_adj[ANG_W-2:DIV_SHIFT];
      d1_qe_q  <= ze_abs[ANG_W-2:DIV_SHIFT];
      d1_neg_q <= el_vec[IT].z < 0;
      d1_f_q   <= el_end.f;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D2: multiply by the reciprocal of 1e9 / 2^9.
  // --------------------------------------------------------------------------
  logic              d2_vld_q;
  logic [PROD_W-1:0] d2_pa_q, d2_pe_q;
  logic              d2_neg_q;
  flags_t            d2_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_vld_q <= 1'b0;
    end else if (en) begin
      d2_vld_q <= d1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_pa_q  <= PROD_W'(d1_qa_q) * PROD_W'(DEG_RECIP);
      d2_pe_q  <= PROD_W'(d1_qe_q) * PROD_W'(DEG_RECIP);
      d2_neg_q <= d1_neg_q;
      d2_f_q   <= d1_f_q;
    end
  end

  // --------------------------------------------------------------------------
  // Final selection: saturate, then apply the exact special cases.
  // --------------------------------------------------------------------------
  logic [DEG_W-1:0]       qa, qe;
  logic [EL_W-2:0]        el_mag;
  logic [AZ_W-1:0]        az_fin;
  logic signed [EL_W-1:0] el_fin;

  always_comb begin
    qa     = d2_pa_q[PROD_W-1:RECIP_SHIFT];
    qe     = d2_pe_q[PROD_W-1:RECIP_SHIFT];
    el_mag = (qe > DEG_W'(90)) ? (EL_W - 1)'(90) : qe[EL_W-2:0];

    if (d2_f_q.zxy) begin
      az_fin = '0;
    end else if (d2_f_q.dyz) begin
      az_fin = d2_f_q.dxp ? AZ_W'(0) : AZ_W'(180);
    end else if (d2_f_q.dxz) begin
      az_fin = d2_f_q.dyp ? AZ_W'(90) : AZ_W'(270);
    end else if (d2_f_q.diag) begin
      if (d2_f_q.dxp) begin
        az_fin = d2_f_q.dyp ? AZ_W'(45) : AZ_W'(315);
      end else begin
        az_fin = d2_f_q.dyp ? AZ_W'(135) : AZ_W'(225);
      end
    end else begin
      az_fin = (qa > DEG_W'(359)) ? AZ_W'(359) : qa[AZ_W-1:0];
    end

    if (d2_f_q.dzz) begin
      el_fin = '0;
    end else if (d2_f_q.zxy) begin
      el_fin = d2_f_q.dzp ? EL_W'(90) : -EL_W'(90);
    end else if (d2_f_q.cone) begin
      el_fin = d2_f_q.dzp ? EL_W'(45) : -EL_W'(45);
    end else begin
      el_fin = d2_neg_q ? -$signed(EL_W'(el_mag)) : $signed(EL_W'(el_mag));
    end
  end

  // --------------------------------------------------------------------------
  // Output queue, two beats deep.
  // --------------------------------------------------------------------------
  logic [AZ_W-1:0]        fifo_az_q [2];
  logic signed [EL_W-1:0] fifo_el_q [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic                   push, pop;

  assign push = en && d2_vld_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_az_q[wr_ptr_q] <= az_fin;
      fifo_el_q[wr_ptr_q] <= el_fin;
    end
  end

  assign out_valid_o     = (cnt_q != '0);
  assign azimuth_deg_o   = fifo_az_q[rd_ptr_q];
  assign elevation_deg_o = fifo_el_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== design/bea3_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// bea3_cordic_stage
// One registered CORDIC vectoring micro-rotation with side payload.
// ----------------------------------------------------------------------------
`default_nettype none

module bea3_cordic_stage
  import bea3_pkg::*;
#(
  parameter int unsigned STAGE = 0,
  parameter int unsigned AUX_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire vec_t             vec_i,
  input  wire logic [AUX_W-1:0] aux_i,
  output logic                  vld_o,
  output vec_t                  vec_o,
  output logic [AUX_W-1:0]      aux_o
);

  localparam logic signed [ANG_W-1:0] STEP = step_angle(STAGE);

  logic signed [DATA_W-1:0] xs, ys;
  vec_t vec_d;

  always_comb begin
    xs = vec_i.x >>> STAGE;
    ys = vec_i.y >>> STAGE;
    // turn toward the x axis
    if (vec_i.y < 0) begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - STEP;
    end else begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_o <= vec_d;
      aux_o <= aux_i;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_bearing_elevation_3d.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bearing_elevation_3d
// Self-checking bench for the azimuth/elevation pipeline.
// ----------------------------------------------------------------------------
// A table of hand-picked point pairs runs first: axes, diagonals, vertical
// lines, cones and the coordinate extremes. Random pairs follow, a mix of
// full-range points, close points and pairs built on axes, diagonals and
// Pythagorean cones. Rows without typed angles and all random pairs go through
// a bit-exact software CORDIC; every result beat is compared field by field
// with the oldest expectation. Both sides idle at random, the receiver holds
// off once for a long stretch and the sender waits after phase one to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bearing_elevation_3d
  import bea3_pkg::*;
();

  localparam longint DEG_UNITS   = 64'sd1000000000;
  localparam longint RAD_UNITS   = 64'sd57295779513;
  localparam longint GAIN_Q30    = 64'sd694453539;
  localparam int     NUM_ROT     = 24;
  localparam int     TOP_BIT     = 55;
  localparam int     HOLD_CYC    = 400;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     DRAIN_CYC   = 80;
  localparam int     N_RANDOM    = 1300;

  typedef struct packed {
    int fx, fy, fz, tx, ty, tz;
  } pair_t;

  typedef struct packed {
    logic [AZ_W-1:0]        az;
    logic signed [EL_W-1:0] el;
  } angles_t;

  typedef struct packed {
    pair_t   p;
    bit      typed;
    angles_t a;
  } dir_row_t;

  localparam int signed CMIN = 32'sh8000_0000;
  localparam int signed CMAX = 32'sh7fff_ffff;

  // Rows with typed angles can be read off by eye; the rest use the predictor.
  localparam int N_DIR = 22;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{'{0, 0, 0, 0, 0, 0},          1'b1, '{9'd0,   8'sd0}},    // zero difference
    '{'{0, 0, 0, 0, 0, 5},          1'b1, '{9'd0,   8'sd90}},   // straight up
    '{'{0, 0, 7, 0, 0, -100},       1'b1, '{9'd0,  -8'sd90}},   // straight down
    '{'{0, 0, 0, 10, 0, 0},         1'b1, '{9'd0,   8'sd0}},    // +x axis
    '{'{5, 0, 0, -5, 0, 0},         1'b1, '{9'd180, 8'sd0}},    // -x axis
    '{'{0, 0, 0, 0, 3, 0},          1'b1, '{9'd90,  8'sd0}},    // +y axis
    '{'{0, 9, 0, 0, -1, 0},         1'b1, '{9'd270, 8'sd0}},    // -y axis
    '{'{0, 0, 0, 1, 1, 0},          1'b1, '{9'd45,  8'sd0}},    // diagonals
    '{'{0, 0, 0, -1, 1, 0},         1'b1, '{9'd135, 8'sd0}},
    '{'{0, 0, 0, -2, -2, 0},        1'b1, '{9'd225, 8'sd0}},
    '{'{0, 0, 0, 7, -7, 0},         1'b1, '{9'd315, 8'sd0}},
    '{'{0, 0, 0, 3, 4, 5},          1'b0, '{9'd0,   8'sd0}},    // cone, up
    '{'{0, 0, 0, 1, 0, -1},         1'b1, '{9'd0,  -8'sd45}},   // cone, down
    '{'{0, 0, 0, 0, -2, 2},         1'b1, '{9'd270, 8'sd45}},
    '{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, 1'b0, '{9'd0, 8'sd0}},
    '{'{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}, 1'b0, '{9'd0, 8'sd0}},
    '{'{CMIN, 0, 0, CMAX, 0, 0},    1'b1, '{9'd0,   8'sd0}},
    '{'{0, CMAX, 0, 0, CMIN, 0},    1'b1, '{9'd270, 8'sd0}},
    '{'{0, 0, CMAX, 0, 0, CMIN},    1'b1, '{9'd0,  -8'sd90}},
    '{'{1, 2, 3, 4, 9, -20},        1'b0, '{9'd0,   8'sd0}},
    '{'{32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
        32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'shaaaa_aaaa}, 1'b0, '{9'd0, 8'sd0}},
    '{'{-3, 17, 40000, 12345, -999, -7}, 1'b0, '{9'd0, 8'sd0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [31:0] from_x_i, from_y_i, from_z_i, to_x_i, to_y_i, to_z_i;
  logic [AZ_W-1:0]        azimuth_deg_o;
  logic signed [EL_W-1:0] elevation_deg_o;

  angles_t angles_q[$];
  int      fails = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      hold_req = 0;
  int      hold_ack = 0;
  int      hold_left = 0;
  int      quiet_cnt = 0;

  bearing_elevation_3d dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .from_x_i        (from_x_i),
    .from_y_i        (from_y_i),
    .from_z_i        (from_z_i),
    .to_x_i          (to_x_i),
    .to_y_i          (to_y_i),
    .to_z_i          (to_z_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .azimuth_deg_o   (azimuth_deg_o),
    .elevation_deg_o (elevation_deg_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Micro-rotation angle in 1e-9 degree: table for coarse steps, then
  // rounded scaled radians once atan(2^-i) ~ 2^-i.
  function automatic longint micro_angle(int i);
    longint coarse [16];
    coarse = '{64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
               64'sd3576334375, 64'sd1789910608, 64'sd895173710, 64'sd447614171,
               64'sd223810500, 64'sd111905677, 64'sd55952892, 64'sd27976453,
               64'sd13988227, 64'sd6994114, 64'sd3497057, 64'sd1748528};
    if (i < 16) return coarse[i];
    return (RAD_UNITS + (64'sd1 <<< (i - 1))) >>> i;
  endfunction

  // Rotate (x, y) onto the +x axis; return the angle swept, leave x scaled.
  function automatic longint rotate_to_axis(inout longint x, input longint y);
    longint ang, xs, ys, t;
    ang = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;  y = -t; ang = 90 * DEG_UNITS;
      end else begin
        x = -y; y = t;  ang = -90 * DEG_UNITS;
      end
    end
    for (int i = 0; i < NUM_ROT; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys; y = y + xs; ang -= micro_angle(i);
      end else begin
        x = x + ys; y = y - xs; ang += micro_angle(i);
      end
    end
    return ang;
  endfunction

  // Multiply by the CORDIC gain so dz matches the already-scaled x.
  function automatic longint apply_gain(longint v);
    longint hi, lo;
    hi = v >>> 30;
    lo = v - (hi <<< 30);
    return v + hi * GAIN_Q30 + ((lo * GAIN_Q30) >>> 30);
  endfunction

  function automatic angles_t predict_angles(pair_t p);
    longint dx, dy, dz, ax, ay, az, x, za, ze, azim, elev;
    logic [63:0] m;
    logic [65:0] hsq, vsq;
    int s;
    angles_t r;
    dx = longint'(p.tx) - longint'(p.fx);
    dy = longint'(p.ty) - longint'(p.fy);
    dz = longint'(p.tz) - longint'(p.fz);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    if (dx == 0 && dy == 0) begin
      azim = 0;
      elev = dz > 0 ? 90 : (dz < 0 ? -90 : 0);
    end else begin
      m = ax > ay ? ax : ay;
      if (az > m) m = az;
      s = 0;
      while (((m << s) >> TOP_BIT) == 0) s++;
      x = dx <<< s;
      za = rotate_to_axis(x, dy <<< s);
      if (za < 0) za += 360 * DEG_UNITS;
      azim = za / DEG_UNITS;
      if (azim > 359) azim = 359;
      if (dy == 0) azim = dx > 0 ? 0 : 180;
      else if (dx == 0) azim = dy > 0 ? 90 : 270;
      else if (ax == ay) begin
        if (dx > 0) azim = dy > 0 ? 45 : 315;
        else azim = dy > 0 ? 135 : 225;
      end
      if (dz == 0) begin
        elev = 0;
      end else begin
        hsq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        vsq = 66'(az) * 66'(az);
        if (hsq == vsq) begin
          elev = dz > 0 ? 45 : -45;
        end else begin
          ze = rotate_to_axis(x, apply_gain(dz <<< s));
          elev = ze / DEG_UNITS;
          if (elev > 90) elev = 90;
          if (elev < -90) elev = -90;
        end
      end
    end
    r.az = azim[AZ_W-1:0];
    r.el = elev[EL_W-1:0];
    return r;
  endfunction

  function automatic int rand_sign(int v);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Random pair: full range, close points, or a shaped offset (axis,
  // diagonal, cone, level, vertical) added to a random origin.
  function automatic pair_t random_pair();
    pair_t p;
    int dx, dy, dz, k, kind;
    int tri_a [3];
    int tri_b [3];
    int tri_c [3];
    tri_a = '{3, 5, 8};
    tri_b = '{4, 12, 15};
    tri_c = '{5, 13, 17};
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(9);
    if (kind >= 3 && kind <= 5) begin
      p.tx = p.fx + $urandom_range(2000) - 1000;
      p.ty = p.fy + $urandom_range(2000) - 1000;
      p.tz = p.fz + $urandom_range(2000) - 1000;
    end else if (kind >= 6) begin
      p.fx = p.fx >>> 2; p.fy = p.fy >>> 2; p.fz = p.fz >>> 2;
      k  = $urandom_range(1, 100000);
      dx = rand_sign($urandom_range(1, 1 << 20));
      dy = rand_sign($urandom_range(1, 1 << 20));
      dz = rand_sign($urandom_range(0, 1 << 20));
      case ($urandom_range(4))
        0: if ($urandom_range(1)) dx = 0; else dy = 0;
        1: dy = $urandom_range(1) ? dx : -dx;
        2: begin
          int j;
          j  = $urandom_range(2);
          dx = rand_sign(tri_a[j] * k);
          dy = rand_sign(tri_b[j] * k);
          dz = rand_sign(tri_c[j] * k);
          if ($urandom_range(1)) begin
            dx = dx + dy; dy = dx - dy; dx = dx - dy;
          end
        end
        3: dz = 0;
        default: begin
          dx = 0; dy = 0;
        end
      endcase
      p.tx = p.fx + dx; p.ty = p.fy + dy; p.tz = p.fz + dz;
    end
    return p;
  endfunction

  // Offer one beat, idling first at the current rate; returns on acceptance.
  task automatic send_pair(pair_t p, angles_t a);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    from_x_i <= p.fx; from_y_i <= p.fy; from_z_i <= p.fz;
    to_x_i   <= p.tx; to_y_i   <= p.ty; to_z_i   <= p.tz;
    do @(posedge clk_i); while (in_stall_o);
    angles_q = {angles_q, a};
  endtask

  task automatic send_predicted(pair_t p);
    send_pair(p, predict_angles(p));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (angles_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    fails++;
  endtask

  // Result side: check each accepted beat, then pick next cycle's stall.
  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (angles_q.size() == 0) begin
        report($sformatf("unexpected beat az=%0d el=%0d",
                         azimuth_deg_o, elevation_deg_o));
      end else begin
        want = angles_q.pop_front();
        if (azimuth_deg_o !== want.az)
          report($sformatf("azimuth %0d, want %0d", azimuth_deg_o, want.az));
        if (elevation_deg_o !== want.el)
          report($sformatf("elevation %0d, want %0d", elevation_deg_o, want.el));
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    out_stall_i <= 1'b0;
    from_x_i <= '0; from_y_i <= '0; from_z_i <= '0;
    to_x_i   <= '0; to_y_i   <= '0; to_z_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: sender idles lightly, receiver stalls often.
    send_idle = 13;
    recv_idle = 61;
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_TAB[r].typed) send_pair(DIR_TAB[r].p, DIR_TAB[r].a);
      else send_predicted(DIR_TAB[r].p);
    end
    for (int n = 0; n < N_RANDOM / 3; n++) send_predicted(random_pair());

    // Hold the sender until the pipeline has emptied.
    wait_drained();

    // Phase two: roles swapped.
    send_idle = 61;
    recv_idle = 13;
    for (int n = 0; n < N_RANDOM / 3; n++) send_predicted(random_pair());

    // Phase three: full rate, with one long receiver hold-off up front so
    // the pipeline backs up into the input.
    send_idle = 0;
    recv_idle = 0;
    hold_req++;
    for (int n = 0; n < N_RANDOM - 2 * (N_RANDOM / 3); n++)
      send_predicted(random_pair());

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
